[src/modbus_tcp_request_server_macros.svh]
// Assertion macros shared by the RTL of the Modbus TCP request server.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef MODBUS_TCP_REQUEST_SERVER_MACROS_SVH
`define MODBUS_TCP_REQUEST_SERVER_MACROS_SVH

// Implication in the same cycle.
`define MBTCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define MBTCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mbtcp_pkg.sv]
// Types and constants of the Modbus TCP request server.
// No dependencies; used by mbtcp_hdr_check and modbus_tcp_request_server.
package mbtcp_pkg;

  localparam int IDX_W = 7;

  localparam logic [2:0] NO_FAULT   = 3'd0;
  localparam logic [2:0] EXC_FUNC   = 3'd1;
  localparam logic [2:0] EXC_ADDR   = 3'd2;
  localparam logic [2:0] EXC_DATA   = 3'd3;
  localparam logic [2:0] EXC_PROTO  = 3'd4;

  localparam logic [7:0] FC_READ_COILS  = 8'd1;
  localparam logic [7:0] FC_READ_DISC   = 8'd2;
  localparam logic [7:0] FC_READ_HOLD   = 8'd3;
  localparam logic [7:0] FC_READ_INPUT  = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FC_WRITE_REG   = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

  localparam logic [15:0] COIL_ON    = 16'hFF00;
  localparam logic [7:0]  EXC_FLAG   = 8'h80;
  localparam logic [15:0] INPUT_INIT = 16'h3131;
  localparam logic [15:0] MAX_WRITE_REGS = 16'd123;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       is_exception;
  } out_item_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] len;
    logic [7:0]  fc;
    logic [15:0] start;
    logic [15:0] qty;
    logic [7:0]  bc;
  } hdr_t;

  typedef struct packed {
    logic [2:0] hdr_code;
    logic [2:0] resp_code;
  } chk_t;

endpackage

[src/mbtcp_hdr_check.sv]
// Header checks of a Modbus TCP request, giving the exception code.
// Depends on mbtcp_pkg and modbus_tcp_request_server_macros.svh.
`include "modbus_tcp_request_server_macros.svh"
module mbtcp_hdr_check #(
  parameter int REG_COUNT     = 64,
  parameter int COIL_BITS     = 64,
  parameter int MAX_READ_REGS = 16,
  parameter int MAX_FRAME_LEN = 253
) (
  input  mbtcp_pkg::hdr_t hdr,
  input  logic [7:0]      n,
  output mbtcp_pkg::chk_t chk
);

  localparam logic [16:0] CB    = 17'(COIL_BITS);
  localparam logic [16:0] RC    = 17'(REG_COUNT);
  localparam logic [15:0] MR    = 16'(MAX_READ_REGS);
  localparam logic [15:0] LEN_MAX = 16'(MAX_FRAME_LEN - 6);

  logic [16:0] sum;
  logic [16:0] q17;
  logic [7:0]  need;
  logic [2:0]  code;
  logic        multi;

  assign sum   = {1'b0, hdr.start} + {1'b0, hdr.qty};
  assign q17   = {1'b0, hdr.qty};
  assign multi = (hdr.fc == mbtcp_pkg::FC_WRITE_COILS) || (hdr.fc == mbtcp_pkg::FC_WRITE_REGS);
  assign need  = multi ? 8'd13 : 8'd12;

  always_comb begin
    code = mbtcp_pkg::NO_FAULT;
    if (hdr.pid != 16'd0) begin
      code = mbtcp_pkg::EXC_PROTO;
    end else if (hdr.len > LEN_MAX) begin
      code = mbtcp_pkg::EXC_DATA;
    end else if (!(hdr.fc inside {mbtcp_pkg::FC_READ_COILS, mbtcp_pkg::FC_READ_DISC,
                                  mbtcp_pkg::FC_READ_HOLD, mbtcp_pkg::FC_READ_INPUT,
                                  mbtcp_pkg::FC_WRITE_COIL, mbtcp_pkg::FC_WRITE_REG,
                                  mbtcp_pkg::FC_WRITE_COILS, mbtcp_pkg::FC_WRITE_REGS})) begin
      code = mbtcp_pkg::EXC_FUNC;
    end else if (n < need) begin
      code = mbtcp_pkg::EXC_DATA;
    end else begin
      case (hdr.fc)
        mbtcp_pkg::FC_READ_COILS, mbtcp_pkg::FC_READ_DISC: begin
          if (q17 == 17'd0 || q17 > CB) code = mbtcp_pkg::EXC_DATA;
          else if (sum > CB) code = mbtcp_pkg::EXC_ADDR;
        end
        mbtcp_pkg::FC_READ_HOLD, mbtcp_pkg::FC_READ_INPUT: begin
          if (hdr.qty == 16'd0 || hdr.qty > MR) code = mbtcp_pkg::EXC_DATA;
          else if (sum > RC) code = mbtcp_pkg::EXC_ADDR;
        end
        mbtcp_pkg::FC_WRITE_COIL: begin
          if (hdr.qty != 16'd0 && hdr.qty != mbtcp_pkg::COIL_ON) code = mbtcp_pkg::EXC_DATA;
          else if ({1'b0, hdr.start} >= CB) code = mbtcp_pkg::EXC_ADDR;
        end
        mbtcp_pkg::FC_WRITE_REG: begin
          if ({1'b0, hdr.start} >= RC) code = mbtcp_pkg::EXC_ADDR;
        end
        mbtcp_pkg::FC_WRITE_COILS: begin
          if (q17 == 17'd0 || q17 > CB || {9'd0, hdr.bc} != ((q17 + 17'd7) >> 3))
            code = mbtcp_pkg::EXC_DATA;
          else if (sum > CB) code = mbtcp_pkg::EXC_ADDR;
        end
        default: begin
          if (hdr.qty == 16'd0 || hdr.qty > mbtcp_pkg::MAX_WRITE_REGS ||
              {9'd0, hdr.bc} != {hdr.qty, 1'b0})
            code = mbtcp_pkg::EXC_DATA;
          else if (sum > RC) code = mbtcp_pkg::EXC_ADDR;
        end
      endcase
    end
  end

  always_comb begin
    chk.hdr_code  = code;
    chk.resp_code = code;
    // A write-multiple frame must carry every data byte that its byte count announces.
    if (code == mbtcp_pkg::NO_FAULT && multi && ({1'b0, n} < (9'd13 + {1'b0, hdr.bc})))
      chk.resp_code = mbtcp_pkg::EXC_DATA;
  end

endmodule

[src/modbus_tcp_request_server.sv]
// Modbus TCP request server: byte-stream request parser, stores and response sequencer.
// Depends on mbtcp_pkg, mbtcp_hdr_check and modbus_tcp_request_server_macros.svh.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall    mbtcp_pkg::in_item_t
//   out_      output     out_valid / out_stall  mbtcp_pkg::out_item_t
//
// Request bytes are taken one per cycle while the block is idle.
// The final byte of a frame starts header evaluation; a frame of eight bytes or more is
// answered at one byte per cycle while out_stall is low, each register word first taking
// a fetch state for its synchronous read port. in_stall stays high until the last byte
// is sent. After reset a clearing pass writes zero to all REG_COUNT holding registers,
// one per cycle, with in_stall high; out_stall only delays the response bytes.
`include "modbus_tcp_request_server_macros.svh"
module modbus_tcp_request_server #(
  parameter int REG_COUNT     = 64,
  parameter int COIL_BYTES    = 8,
  parameter int MAX_READ_REGS = 16,
  parameter int MAX_FRAME_LEN = 253
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mbtcp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mbtcp_pkg::out_item_t out_data
);

  localparam int COIL_BITS = COIL_BYTES * 8;
  localparam int AW        = $clog2(REG_COUNT);
  localparam logic [8:0] POS_LIM = (MAX_FRAME_LEN < 255) ? 9'(MAX_FRAME_LEN) : 9'd255;
  localparam int IW        = mbtcp_pkg::IDX_W;

  typedef enum logic [4:0] {
    ST_CLR   = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CALC  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [7:0]             pos_r, pos_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic [7:0]             hb_r [13];
  logic [COIL_BITS-1:0]   coil_r, coil_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [IW-1:0]          tot_r, tot_nxt;
  logic [7:0]             nb_r, nb_nxt;
  logic [2:0]             code_r, code_nxt;
  logic                   exc_r, exc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  mbtcp_pkg::out_item_t   out_r, out_nxt;

  logic [15:0]            hold_mem [REG_COUNT];
  logic [15:0]            rd_q;
  logic [15:0]            inp_q;
  logic                   we;
  logic [AW-1:0]          wa;
  logic [15:0]            wd;
  logic [AW-1:0]          ra;

  mbtcp_pkg::hdr_t        hdr;
  mbtcp_pkg::chk_t        chk;
  logic                   acc;
  logic                   can_send;
  logic [7:0]             k;
  logic [16:0]            sh_in;
  logic [7:0]             m_in;
  logic [COIL_BITS-1:0]   cw_val, cw_mask;
  logic [IW-1:0]          ri;
  logic [16:0]            sh_out;
  logic [7:0]             m_out;
  logic [COIL_BITS-1:0]   coil_sh;
  logic [16:0]            raddr17;
  logic [15:0]            word;
  logic [7:0]             byte_val;
  logic [15:0]            len16;
  logic                   is_read;
  logic                   is_reg_read;

  assign hdr.pid   = {hb_r[2], hb_r[3]};
  assign hdr.len   = {hb_r[4], hb_r[5]};
  assign hdr.fc    = hb_r[7];
  assign hdr.start = {hb_r[8], hb_r[9]};
  assign hdr.qty   = {hb_r[10], hb_r[11]};
  assign hdr.bc    = hb_r[12];

  mbtcp_hdr_check #(
    .REG_COUNT     (REG_COUNT),
    .COIL_BITS     (COIL_BITS),
    .MAX_READ_REGS (MAX_READ_REGS),
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_check (
    .hdr (hdr),
    .n   (pos_r),
    .chk (chk)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign acc       = in_valid && !in_stall;
  assign can_send  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_read     = (hdr.fc inside {mbtcp_pkg::FC_READ_COILS, mbtcp_pkg::FC_READ_DISC,
                                       mbtcp_pkg::FC_READ_HOLD, mbtcp_pkg::FC_READ_INPUT});
  assign is_reg_read = (hdr.fc == mbtcp_pkg::FC_READ_HOLD) ||
                       (hdr.fc == mbtcp_pkg::FC_READ_INPUT);

  // Streamed write data: k counts data bytes after the 13-byte header.
  assign k     = pos_r - 8'd13;
  assign sh_in = {1'b0, hdr.start} + {6'd0, k, 3'b000};
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      m_in[i] = (({5'd0, k, 3'b000} + 16'(i)) < hdr.qty);
    end
  end
  assign cw_val  = COIL_BITS'(in_data.rx_byte & m_in) << sh_in;
  assign cw_mask = COIL_BITS'(m_in) << sh_in;

  // Coil read-back: ri is the data byte number within the response.
  assign ri     = idx_r - IW'(9);
  assign sh_out = {1'b0, hdr.start} + {7'd0, ri, 3'b000};
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      m_out[i] = (({6'd0, ri, 3'b000} + 16'(i)) < hdr.qty);
    end
  end
  assign coil_sh = coil_r >> sh_out;

  assign raddr17 = {1'b0, hdr.start} + 17'(ri >> 1);
  assign ra      = raddr17[AW-1:0];
  assign word    = (hdr.fc == mbtcp_pkg::FC_READ_HOLD) ? rd_q : inp_q;
  assign len16   = {8'd0, nb_r} + 16'd3;

  always_comb begin
    byte_val = 8'd0;
    case (idx_r)
      IW'(0): byte_val = hb_r[0];
      IW'(1): byte_val = hb_r[1];
      IW'(2): byte_val = hb_r[2];
      IW'(3): byte_val = hb_r[3];
      IW'(4): byte_val = (exc_r || !is_read) ? 8'd0 : len16[15:8];
      IW'(5): byte_val = exc_r ? 8'd3 : (is_read ? len16[7:0] : 8'd6);
      IW'(6): byte_val = hb_r[6];
      IW'(7): byte_val = exc_r ? (hdr.fc | mbtcp_pkg::EXC_FLAG) : hdr.fc;
      IW'(8): byte_val = exc_r ? {5'd0, code_r} : (is_read ? nb_r : hb_r[8]);
      default: begin
        if (!is_read) begin
          case (idx_r)
            IW'(9):  byte_val = hb_r[9];
            IW'(10): byte_val = hb_r[10];
            default: byte_val = hb_r[11];
          endcase
        end else if (is_reg_read) begin
          byte_val = idx_r[0] ? word[15:8] : word[7:0];
        end else begin
          byte_val = coil_sh[7:0] & m_out;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    coil_nxt      = coil_r;
    idx_nxt       = idx_r;
    tot_nxt       = tot_r;
    nb_nxt        = nb_r;
    code_nxt      = code_r;
    exc_nxt       = exc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    we            = 1'b0;
    wa            = clr_r;
    wd            = 16'd0;

    case (state_r)
      ST_CLR: begin
        we      = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(REG_COUNT - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          if ({1'b0, pos_r} < POS_LIM) begin
            pos_nxt = pos_r + 8'd1;
            if (pos_r >= 8'd13 && chk.hdr_code == mbtcp_pkg::NO_FAULT) begin
              if (hdr.fc == mbtcp_pkg::FC_WRITE_REGS) begin
                if (!k[0]) begin
                  pend_nxt = in_data.rx_byte;
                end else if ({9'd0, k[7:1]} < hdr.qty &&
                             ({1'b0, hdr.start} + {10'd0, k[7:1]}) < 17'(REG_COUNT)) begin
                  we = 1'b1;
                  wa = AW'(hdr.start + {9'd0, k[7:1]});
                  wd = {pend_r, in_data.rx_byte};
                end
              end else if (hdr.fc == mbtcp_pkg::FC_WRITE_COILS && k < hdr.bc) begin
                coil_nxt = (coil_r & ~cw_mask) | cw_val;
              end
            end
          end
          if (in_data.frame_end) state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        pos_nxt  = 8'd0;
        pend_nxt = 8'd0;
        idx_nxt  = '0;
        code_nxt = chk.resp_code;
        exc_nxt  = (chk.resp_code != mbtcp_pkg::NO_FAULT);
        nb_nxt   = (hdr.fc <= mbtcp_pkg::FC_READ_DISC) ? 8'((hdr.qty + 16'd7) >> 3)
                                                      : 8'({hdr.qty, 1'b0});
        if (chk.resp_code != mbtcp_pkg::NO_FAULT) tot_nxt = IW'(9);
        else if (is_read) tot_nxt = IW'(9) + IW'(nb_nxt);
        else tot_nxt = IW'(12);
        if (pos_r < 8'd8) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
          if (chk.resp_code == mbtcp_pkg::NO_FAULT) begin
            if (hdr.fc == mbtcp_pkg::FC_WRITE_COIL) begin
              if (hdr.qty == mbtcp_pkg::COIL_ON)
                coil_nxt = coil_r | (COIL_BITS'(1) << hdr.start);
              else
                coil_nxt = coil_r & ~(COIL_BITS'(1) << hdr.start);
            end else if (hdr.fc == mbtcp_pkg::FC_WRITE_REG) begin
              we = 1'b1;
              wa = hdr.start[AW-1:0];
              wd = hdr.qty;
            end
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_send) begin
          out_valid_nxt        = 1'b1;
          out_nxt.tx_byte      = byte_val;
          out_nxt.tx_last      = (idx_r == tot_r - IW'(1));
          out_nxt.is_exception = exc_r;
          idx_nxt              = idx_r + IW'(1);
          if (idx_r == tot_r - IW'(1)) begin
            state_nxt = ST_IDLE;
          end else if (!exc_r && is_reg_read && idx_r >= IW'(8) && !idx_r[0]) begin
            // The next byte opens a new register word, which needs a memory read first.
            state_nxt = ST_FETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) hold_mem[wa] <= wd;
    rd_q  <= hold_mem[ra];
    inp_q <= (raddr17 < 17'd2) ? mbtcp_pkg::INPUT_INIT : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (acc && pos_r < 8'd13 && {1'b0, pos_r} < POS_LIM) begin
      hb_r[pos_r[3:0]] <= in_data.rx_byte;
    end
    idx_r  <= idx_nxt;
    tot_r  <= tot_nxt;
    nb_r   <= nb_nxt;
    code_r <= code_nxt;
    exc_r  <= exc_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      pos_r       <= 8'd0;
      pend_r      <= 8'd0;
      coil_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      coil_r      <= coil_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MBTCP_ASSERT_NEXT(a_end_to_calc, acc && in_data.frame_end, state_r == ST_CALC, "frame end not evaluated")
  `MBTCP_ASSERT_NEXT(a_last_to_idle, state_r == ST_EMIT && can_send && idx_r == tot_r - IW'(1), state_r == ST_IDLE && out_data.tx_last, "response did not close")
  `MBTCP_ASSERT_NOW(a_exc_len, state_r == ST_EMIT && exc_r, tot_r == IW'(9), "exception reply length wrong")

endmodule
